// ===== design/mfc_pkg.sv =====
// Shared types and constants for the music fade and cross fade controller.
package mfc_pkg;

   localparam int SONG_SLOTS = 16;

   localparam int VOL_W  = 11;
   localparam int LEN_W  = 16;
   localparam int TIME_W = 32;
   localparam int SLOT_W = 4;
   localparam int PROD_W = VOL_W + LEN_W;

   localparam logic [VOL_W-1:0] FULL_SCALE   = 11'd1024;
   localparam logic [VOL_W-1:0] RESET_VOLUME = 11'd600;

   typedef enum logic [2:0] {
      MODE_NONE   = 3'd0,
      MODE_IN     = 3'd1,
      MODE_OUT    = 3'd2,
      MODE_OUT_IN = 3'd3,
      MODE_CROSS  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      REQ_TICK     = 3'd0,
      REQ_PLAY     = 3'd1,
      REQ_STOP     = 3'd2,
      REQ_FADE_IN  = 3'd3,
      REQ_FADE_OUT = 3'd4,
      REQ_OUT_IN   = 3'd5,
      REQ_CROSS    = 3'd6
   } request_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MAIN,
      ST_ALT,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } mfc_state_type;

   // Divider start command and result
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [LEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [VOL_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== design/mfc_div.sv =====
// Serial restoring divider, one quotient bit per cycle, for volume ramps.
module mfc_div (
   input  logic                clock,
   input  logic                reset,
   input  mfc_pkg::div_req_type div_req,
   output mfc_pkg::div_rsp_type div_rsp
);
   import mfc_pkg::*;

   localparam int STEPS = VOL_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [VOL_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [LEN_W:0]   trial;
   logic             ge;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[VOL_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         // Quotient is known to fit VOL_W bits, so the top part is below the divisor
         rem_in  = div_req.dividend[PROD_W-1:VOL_W];
         quo_in  = div_req.dividend[VOL_W-1:0];
         div_in  = div_req.divisor;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? LEN_W'(trial - {1'b0, div_ff}) : trial[LEN_W-1:0];
         quo_in = {quo_ff[VOL_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== design/music_fade_crossfade_controller.sv =====
// Top level: two-voice music volume controller with linear fades and cross fade.
// Sequence: a command passes from accept through an execute state to the result
// state; a tick runs the main voice and then the alternate voice, and each voice that
// is ramping adds a multiply state, an 11-step serial divide and the divider's done strobe.
// One item at a time: a new request is stalled until the last result is taken.
// Reset is synchronous: both voices off, volumes and global volume at 600.
module music_fade_crossfade_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_type,
   input  logic [mfc_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [mfc_pkg::SLOT_W-1:0]     req_song_slot,
   input  logic [mfc_pkg::LEN_W-1:0]      req_fade_ms,
   input  logic [mfc_pkg::LEN_W-1:0]      req_second_fade_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_main_active,
   output logic [mfc_pkg::SLOT_W-1:0]     rsp_main_slot,
   output logic [mfc_pkg::VOL_W-1:0]      rsp_main_volume,
   output logic [2:0]                     rsp_main_mode,
   output logic                           rsp_alt_active,
   output logic [mfc_pkg::SLOT_W-1:0]     rsp_alt_slot,
   output logic [mfc_pkg::VOL_W-1:0]      rsp_alt_volume,
   output logic [2:0]                     rsp_alt_mode,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mfc_pkg::VOL_W-1:0]      csr_global_volume
);
   import mfc_pkg::*;

   mfc_state_type    state_ff, state_in;

   logic [VOL_W-1:0] glob_ff;
   logic [VOL_W-1:0] full_lvl;

   // Captured item
   logic [2:0]        type_ff, type_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  len2_ff, len2_in;

   // Voice state
   logic              main_on_ff, main_on_in;
   logic [SLOT_W-1:0] main_song_ff, main_song_in;
   mode_type          main_fade_ff, main_fade_in;
   logic [TIME_W-1:0] main_start_ff, main_start_in;
   logic [LEN_W-1:0]  main_len_ff, main_len_in;
   logic [VOL_W-1:0]  main_level_ff, main_level_in;
   logic              alt_on_ff, alt_on_in;
   logic [SLOT_W-1:0] alt_song_ff, alt_song_in;
   mode_type          alt_fade_ff, alt_fade_in;
   logic [TIME_W-1:0] alt_start_ff, alt_start_in;
   logic [LEN_W-1:0]  alt_len_ff, alt_len_in;
   logic [VOL_W-1:0]  alt_level_ff, alt_level_in;
   logic [SLOT_W-1:0] q_song_ff, q_song_in;
   logic [LEN_W-1:0]  q_len_ff, q_len_in;

   // Ramp operands
   logic [LEN_W-1:0]  num_ff, num_in;
   logic [LEN_W-1:0]  den_ff, den_in;
   logic              tgt_alt_ff, tgt_alt_in;

   logic [TIME_W-1:0] main_e, alt_e;
   logic              main_exp, alt_exp;

   logic              st_go;
   logic [SLOT_W-1:0] st_slot;
   logic [LEN_W-1:0]  st_len;
   logic              st_slot_ok;
   logic              accept;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   mfc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign full_lvl = (glob_ff > FULL_SCALE) ? FULL_SCALE : glob_ff;
   assign accept   = req_valid && !req_stall;

   // Elapsed time of each voice and expiry test
   assign main_e   = now_ff - main_start_ff;
   assign alt_e    = now_ff - alt_start_ff;
   assign main_exp = main_e >= {{(TIME_W-LEN_W){1'b0}}, main_len_ff};
   assign alt_exp  = alt_e >= {{(TIME_W-LEN_W){1'b0}}, alt_len_ff};

   assign st_slot_ok = 32'(st_slot) < SONG_SLOTS;

   // Start the divide from the registered multiply operands
   always_comb begin
      div_req.start    = (state_ff == ST_MUL);
      div_req.dividend = PROD_W'(full_lvl) * PROD_W'(num_ff);
      div_req.divisor  = den_ff;
   end

   // Sequencer and state update
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      now_in        = now_ff;
      slot_in       = slot_ff;
      len_in        = len_ff;
      len2_in       = len2_ff;
      main_on_in    = main_on_ff;
      main_song_in  = main_song_ff;
      main_fade_in  = main_fade_ff;
      main_start_in = main_start_ff;
      main_len_in   = main_len_ff;
      main_level_in = main_level_ff;
      alt_on_in     = alt_on_ff;
      alt_song_in   = alt_song_ff;
      alt_fade_in   = alt_fade_ff;
      alt_start_in  = alt_start_ff;
      alt_len_in    = alt_len_ff;
      alt_level_in  = alt_level_ff;
      q_song_in     = q_song_ff;
      q_len_in      = q_len_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      tgt_alt_in    = tgt_alt_ff;
      st_go         = 1'b0;
      st_slot       = slot_ff;
      st_len        = len_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_in  = req_type;
               now_in   = req_now_ms;
               slot_in  = req_song_slot;
               len_in   = req_fade_ms;
               len2_in  = req_second_fade_ms;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            case (type_ff)
               REQ_TICK: state_in = ST_MAIN;
               REQ_PLAY: begin
                  st_go  = 1'b1;
                  st_len = '0;
               end
               REQ_STOP: begin
                  main_on_in = 1'b0;
                  alt_on_in  = 1'b0;
               end
               REQ_FADE_IN: st_go = 1'b1;
               REQ_FADE_OUT: begin
                  if (main_on_ff) begin
                     if (len_ff == '0) begin
                        main_on_in   = 1'b0;
                        alt_on_in    = 1'b0;
                        main_fade_in = MODE_NONE;
                     end else begin
                        main_fade_in  = MODE_OUT;
                        main_start_in = now_ff;
                        main_len_in   = len_ff;
                        main_level_in = full_lvl;
                     end
                  end
               end
               REQ_OUT_IN: begin
                  if (len_ff == '0 || !main_on_ff) begin
                     st_go  = 1'b1;
                     st_len = len2_ff;
                  end else begin
                     q_song_in     = slot_ff;
                     q_len_in      = len2_ff;
                     main_fade_in  = MODE_OUT_IN;
                     main_start_in = now_ff;
                     main_len_in   = len_ff;
                     main_level_in = full_lvl;
                  end
               end
               REQ_CROSS: begin
                  if (len_ff == '0 || !main_on_ff) begin
                     st_go = 1'b1;
                  end else if (st_slot_ok) begin
                     alt_on_in     = 1'b1;
                     alt_song_in   = slot_ff;
                     alt_fade_in   = MODE_CROSS;
                     alt_start_in  = now_ff;
                     alt_len_in    = len_ff;
                     alt_level_in  = '0;
                     main_fade_in  = MODE_CROSS;
                     main_start_in = now_ff;
                     main_len_in   = len_ff;
                     main_level_in = full_lvl;
                  end
               end
               default: ;
            endcase
         end
         ST_MAIN: begin
            // Run the main voice first
            state_in   = ST_ALT;
            tgt_alt_in = 1'b0;
            den_in     = main_len_ff;
            if (main_on_ff && main_fade_ff != MODE_NONE) begin
               if (main_exp) begin
                  case (main_fade_ff)
                     MODE_IN: begin
                        main_level_in = full_lvl;
                        main_fade_in  = MODE_NONE;
                     end
                     MODE_OUT: begin
                        main_on_in    = 1'b0;
                        alt_on_in     = 1'b0;
                        main_level_in = full_lvl;
                        main_fade_in  = MODE_NONE;
                     end
                     MODE_OUT_IN: begin
                        st_go   = 1'b1;
                        st_slot = q_song_ff;
                        st_len  = q_len_ff;
                     end
                     default: ;
                  endcase
               end else begin
                  case (main_fade_ff)
                     MODE_IN: begin
                        num_in   = main_e[LEN_W-1:0];
                        state_in = ST_MUL;
                     end
                     MODE_OUT, MODE_OUT_IN, MODE_CROSS: begin
                        num_in   = main_len_ff - main_e[LEN_W-1:0];
                        state_in = ST_MUL;
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_ALT: begin
            // Then the alternate voice, swapping into main when its fade ends
            state_in   = ST_OUT;
            tgt_alt_in = 1'b1;
            den_in     = alt_len_ff;
            if (alt_on_ff && alt_fade_ff == MODE_CROSS) begin
               if (alt_exp) begin
                  main_on_in    = 1'b1;
                  main_song_in  = alt_song_ff;
                  main_fade_in  = MODE_NONE;
                  main_level_in = full_lvl;
                  alt_on_in     = 1'b0;
               end else begin
                  num_in   = alt_e[LEN_W-1:0];
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               if (tgt_alt_ff) begin
                  alt_level_in = div_rsp.quotient;
                  state_in     = ST_OUT;
               end else begin
                  main_level_in = div_rsp.quotient;
                  state_in      = ST_ALT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // Start the main voice on a slot, immediately or with a fade in
      if (st_go) begin
         if (!st_slot_ok) begin
            main_on_in = 1'b0;
         end else begin
            main_on_in   = 1'b1;
            main_song_in = st_slot;
            if (st_len == '0) begin
               main_fade_in  = MODE_NONE;
               main_level_in = full_lvl;
            end else begin
               main_fade_in  = MODE_IN;
               main_start_in = now_ff;
               main_len_in   = st_len;
               main_level_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         glob_ff       <= RESET_VOLUME;
         main_on_ff    <= 1'b0;
         main_song_ff  <= '0;
         main_fade_ff  <= MODE_NONE;
         main_start_ff <= '0;
         main_len_ff   <= '0;
         main_level_ff <= RESET_VOLUME;
         alt_on_ff     <= 1'b0;
         alt_song_ff   <= '0;
         alt_fade_ff   <= MODE_NONE;
         alt_start_ff  <= '0;
         alt_len_ff    <= '0;
         alt_level_ff  <= RESET_VOLUME;
         q_song_ff     <= '0;
         q_len_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         if (csr_valid && csr_ready) glob_ff <= csr_global_volume;
         main_on_ff    <= main_on_in;
         main_song_ff  <= main_song_in;
         main_fade_ff  <= main_fade_in;
         main_start_ff <= main_start_in;
         main_len_ff   <= main_len_in;
         main_level_ff <= main_level_in;
         alt_on_ff     <= alt_on_in;
         alt_song_ff   <= alt_song_in;
         alt_fade_ff   <= alt_fade_in;
         alt_start_ff  <= alt_start_in;
         alt_len_ff    <= alt_len_in;
         alt_level_ff  <= alt_level_in;
         q_song_ff     <= q_song_in;
         q_len_ff      <= q_len_in;
      end
      type_ff    <= type_in;
      now_ff     <= now_in;
      slot_ff    <= slot_in;
      len_ff     <= len_in;
      len2_ff    <= len2_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      tgt_alt_ff <= tgt_alt_in;
   end

   // Handshakes and result fields straight from the voice state
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign csr_ready       = 1'b1;
   assign rsp_main_active = main_on_ff;
   assign rsp_main_slot   = main_song_ff;
   assign rsp_main_volume = main_level_ff;
   assign rsp_main_mode   = main_fade_ff;
   assign rsp_alt_active  = alt_on_ff;
   assign rsp_alt_slot    = alt_song_ff;
   assign rsp_alt_volume  = alt_level_ff;
   assign rsp_alt_mode    = alt_fade_ff;

endmodule

// ===== design/mfc_checker.sv =====
// Port-level checks for the music fade controller, bound to the top level.
module mfc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_main_active,
   input logic [mfc_pkg::VOL_W-1:0]  rsp_main_volume,
   input logic                       rsp_alt_active,
   input logic [mfc_pkg::VOL_W-1:0]  rsp_alt_volume,
   input logic [2:0]                 rsp_alt_mode
);
   import mfc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // No result in the cycle right after an item is taken
   a_no_same_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result shown too early");

   // One item in flight: no new item while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item taken while result pending");

   // Volumes never exceed full scale
   a_vol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_main_volume <= FULL_SCALE) && (rsp_alt_volume <= FULL_SCALE))
      else $error("volume above full scale");

   // An active alternate voice is always a cross fade beside an active main voice
   a_alt_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alt_active |-> rsp_main_active && (rsp_alt_mode == MODE_CROSS))
      else $error("alternate voice active outside cross fade");

endmodule

bind music_fade_crossfade_controller mfc_checker u_mfc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_main_active (rsp_main_active),
   .rsp_main_volume (rsp_main_volume),
   .rsp_alt_active  (rsp_alt_active),
   .rsp_alt_volume  (rsp_alt_volume),
   .rsp_alt_mode    (rsp_alt_mode)
);
